// ===== rtl/core/gfds_pkg.sv =====
package gfds_pkg;

	localparam logic [1:0] OP_STORE  = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SELECT = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	localparam int HIT_THRESHOLD = 2;

	localparam int IN_BYTES  = 7;
	localparam int OUT_BYTES = 2;

	// Command broadcast to every queue slot for one beat.
	typedef struct packed {
		logic       store;   // write the append slot
		logic       remove;  // compact the queue, dropping tag matches
		logic [7:0] slot;    // append slot index (wide enough for depths up to 256)
	} gfds_cmd_t;

endpackage

// ===== rtl/core/gfds_cell.sv =====
// One queue slot: holds one entry and takes a later slot's surviving entry on compaction.
module gfds_cell
	import gfds_pkg::*;
#(
	parameter int ROW_BITS = 17,
	parameter int TAG_BITS = 8,
	parameter int IDX      = 0
) (
	input  logic                clk,
	input  logic                sel,        // this cell belongs to the addressed queue
	input  gfds_cmd_t           cmd,
	input  logic                shift_in,   // compaction moves this cell
	input  logic [ROW_BITS-1:0] in_row,
	input  logic [TAG_BITS-1:0] in_tag,
	input  logic [ROW_BITS-1:0] nb_row,     // gathered source entry for compaction
	input  logic [TAG_BITS-1:0] nb_tag,
	output logic [ROW_BITS-1:0] row_q,
	output logic [TAG_BITS-1:0] tag_q
);

	always_ff @(posedge clk) begin
		if (sel && cmd.store && cmd.slot == 8'(IDX)) begin
			row_q <= in_row;
			tag_q <= in_tag;
		end else if (sel && cmd.remove && shift_in) begin
			row_q <= nb_row;
			tag_q <= nb_tag;
		end
	end

endmodule

// ===== rtl/core/gfds_queue.sv =====
// One bank-direction queue: a chain of cells with a fill count.
module gfds_queue
	import gfds_pkg::*;
#(
	parameter int QUEUE_DEPTH = 8,
	parameter int ROW_BITS    = 17,
	parameter int TAG_BITS    = 8,
	localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sel,
	input  gfds_cmd_t                     cmd,
	input  logic [ROW_BITS-1:0]           in_row,
	input  logic [TAG_BITS-1:0]           in_tag,
	output logic [CW-1:0]                 count_q,
	output logic [QUEUE_DEPTH-1:0]        hit_row,
	output logic [QUEUE_DEPTH-1:0]        hit_tag,
	output logic [QUEUE_DEPTH-1:0][ROW_BITS-1:0] rows,
	output logic [QUEUE_DEPTH-1:0][TAG_BITS-1:0] tags
);

	logic [QUEUE_DEPTH-1:0] live;
	logic [QUEUE_DEPTH-1:0] del;
	logic [QUEUE_DEPTH-1:0][CW-1:0] src;   // index whose entry lands here
	logic [QUEUE_DEPTH-1:0] mv;
	logic [CW-1:0] keep;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			live[i]    = CW'(i) < count_q;
			hit_row[i] = live[i] && rows[i] == in_row;
			hit_tag[i] = live[i] && tags[i] == in_tag;
			del[i]     = hit_tag[i];
		end
		keep = count_q - CW'($countones(del));
	end

	// Gather: cell k takes the k-th surviving entry.
	always_comb begin
		logic [CW-1:0] k;
		k = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			src[i] = CW'(i);
			mv[i]  = 1'b0;
		end
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (live[i] && !del[i]) begin
				src[k[$clog2(QUEUE_DEPTH)-1:0]] = CW'(i);
				mv[k[$clog2(QUEUE_DEPTH)-1:0]]  = 1'b1;
				k = k + 1'b1;
			end
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		gfds_cell #(.ROW_BITS(ROW_BITS), .TAG_BITS(TAG_BITS), .IDX(g)) u_cell (
			.clk     (clk),
			.sel     (sel),
			.cmd     (cmd),
			.shift_in(mv[g]),
			.in_row  (in_row),
			.in_tag  (in_tag),
			.nb_row  (rows[src[g][$clog2(QUEUE_DEPTH)-1:0]]),
			.nb_tag  (tags[src[g][$clog2(QUEUE_DEPTH)-1:0]]),
			.row_q   (rows[g]),
			.tag_q   (tags[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (sel && cmd.store) begin
			count_q <= count_q + 1'b1;
		end else if (sel && cmd.remove) begin
			count_q <= keep;
		end
	end

endmodule

// ===== rtl/core/grouped_frfcfs_dram_scheduler_core.sv =====
// Per-bank read/write request queues with grouped FR-FCFS selection. Each
// beat is captured into the stage registers, then the addressed queue's
// cells are compared in parallel and the state is updated as the result
// is registered; a new beat is taken once no beat is in flight and the
// result register is free. Every bank-direction queue is a chain of
// QUEUE_DEPTH cells; remove compacts survivors toward the head, keeping order.
module grouped_frfcfs_dram_scheduler_core
	import gfds_pkg::*;
#(
	parameter int NUM_BANKS   = 16,
	parameter int QUEUE_DEPTH = 8,
	parameter int ROW_BITS    = 17,
	parameter int TAG_BITS    = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// operation[1:0], bank[5:2], is_write[6], row[23:7], request_tag[31:24],
	// bank_active[32], open_row[49:33]
	input  logic [IN_BYTES*8-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// status[1:0], found[2], chosen_tag[10:3], chosen_is_write[11],
	// further_row_hit[12], further_request[13]
	output logic [OUT_BYTES*8-1:0] m_tdata
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NQ = 2 * NUM_BANKS;

	logic                busy_q;
	logic [1:0]          op_s1;
	logic [3:0]          bank_s1;
	logic                dir_s1;
	logic [ROW_BITS-1:0] row_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic                act_s1;
	logic [ROW_BITS-1:0] orow_s1;
	logic                last_wr_q;
	logic [15:0]         out_q;
	logic                ovalid_q;

	assign s_tready = !busy_q && !(ovalid_q && !m_tready);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tdata[1:0];
			bank_s1 <= s_tdata[5:2];
			dir_s1  <= s_tdata[6];
			row_s1  <= ROW_BITS'(s_tdata[23:7]);
			tag_s1  <= TAG_BITS'(s_tdata[31:24]);
			act_s1  <= s_tdata[32];
			orow_s1 <= ROW_BITS'(s_tdata[49:33]);
		end
	end

	logic bank_ok;
	assign bank_ok = 32'(bank_s1) < 32'(NUM_BANKS);

	logic [NQ-1:0][CW-1:0] counts;
	logic [NQ-1:0][QUEUE_DEPTH-1:0] hrow, htag;
	logic [NQ-1:0][QUEUE_DEPTH-1:0][ROW_BITS-1:0] rows;
	logic [NQ-1:0][QUEUE_DEPTH-1:0][TAG_BITS-1:0] tags;
	gfds_cmd_t cmd;
	logic [NQ-1:0] qsel;
	logic [$clog2(NQ)-1:0] qidx;
	logic [CW-1:0] cur_cnt;
	logic full;

	assign qidx    = $clog2(NQ)'({bank_s1, dir_s1});
	assign cur_cnt = bank_ok ? counts[qidx] : '0;
	assign full    = 32'(cur_cnt) >= 32'(QUEUE_DEPTH);

	always_comb begin
		cmd.store  = busy_q && op_s1 == OP_STORE && bank_ok && !full;
		cmd.remove = busy_q && op_s1 == OP_REMOVE && bank_ok;
		cmd.slot   = 8'(cur_cnt);
		for (int q = 0; q < NQ; q++)
			qsel[q] = bank_ok && 32'(q) == 32'({28'd0, bank_s1} * 2 + {31'd0, dir_s1});
	end

	for (genvar q = 0; q < NQ; q++) begin : g_q
		gfds_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .ROW_BITS(ROW_BITS), .TAG_BITS(TAG_BITS))
		u_q (
			.clk    (clk),
			.arst_n (arst_n),
			.sel    (qsel[q]),
			.cmd    (cmd),
			.in_row (row_s1),
			.in_tag (tag_s1),
			.count_q(counts[q]),
			.hit_row(hrow[q]),
			.hit_tag(htag[q]),
			.rows   (rows[q]),
			.tags   (tags[q])
		);
	end

	// Result logic over the addressed bank's two queues.
	logic [1:0]  r_status;
	logic        r_found, r_cdir, r_hit2, r_req2;
	logic [7:0]  r_ctag;

	always_comb begin
		logic       dq;
		logic       pick;
		logic [TAG_BITS-1:0] t;
		logic [CW-1:0] n;
		logic [$clog2(NQ)-1:0] qi;
		r_status = ST_OK;
		r_found = 1'b0; r_cdir = 1'b0; r_ctag = '0; r_hit2 = 1'b0; r_req2 = 1'b0;
		dq = 1'b0; pick = 1'b0; t = '0; n = '0; qi = '0;
		unique case (op_s1)
			OP_STORE:  r_status = (bank_ok && !full) ? ST_OK : ST_FULL;
			OP_REMOVE: r_status = (bank_ok && |htag[qidx]) ? ST_OK : ST_NOTFOUND;
			OP_SELECT: begin
				if (bank_ok) begin
					for (int p = 0; p < 2; p++) begin
						qi = $clog2(NQ)'({bank_s1, last_wr_q ^ p[0]});
						n  = counts[qi];
						if (!pick && n != '0) begin
							pick = 1'b1;
							t = tags[qi][0];
							dq = last_wr_q ^ p[0];
							if (act_s1) begin
								for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
									if (CW'(i) < n && rows[qi][i] == orow_s1)
										t = tags[qi][i];
							end
						end
					end
				end
				r_found = pick;
				r_ctag  = 8'(t);
				r_cdir  = dq;
			end
			OP_QUERY: begin
				if (bank_ok) begin
					r_hit2 = $countones(hrow[qidx]) >= HIT_THRESHOLD;
					r_req2 = 32'(counts[qidx]) >= HIT_THRESHOLD;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			ovalid_q  <= 1'b0;
			last_wr_q <= 1'b0;
		end else if (busy_q) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b1;
			if (op_s1 == OP_REMOVE) last_wr_q <= dir_s1;
		end else begin
			if (s_tvalid && s_tready) busy_q <= 1'b1;
			if (m_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q)
			out_q <= {2'b00, r_req2, r_hit2, r_cdir, r_ctag, r_found, r_status};
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !s_tready) else $error("beat accepted while busy");
	a_result_next: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> m_tvalid) else $error("result missing");
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[2]) |-> m_tdata[10:3] == 8'd0) else $error("tag without find");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import gfds_pkg::*;

	localparam int BANKS = 16;
	localparam int DEPTH = 8;

	typedef struct packed {
		logic [16:0] open_row;
		logic        bank_active;
		logic [7:0]  request_tag;
		logic [16:0] row;
		logic        is_write;
		logic [3:0]  bank;
		logic [1:0]  operation;
	} sched_req_t;

	typedef struct packed {
		logic       further_request;
		logic       further_row_hit;
		logic       chosen_is_write;
		logic [7:0] chosen_tag;
		logic       found;
		logic [1:0] status;
	} sched_rsp_t;

	typedef struct {
		sched_req_t req;
		logic       typed;
		sched_rsp_t rsp;
	} drill_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_BYTES*8-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_BYTES*8-1:0] m_tdata;

	grouped_frfcfs_dram_scheduler_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// mirror of the bank queues
	logic [16:0] mq_row [2][BANKS][DEPTH];
	logic [7:0]  mq_tag [2][BANKS][DEPTH];
	int          mq_cnt [2][BANKS];
	logic        served_write;

	sched_rsp_t pending_rsp[$];
	int errors;
	int beats_in, beats_out, n_store, n_remove, n_select, n_query;
	bit stall_hold;

	initial begin
		clk = 0;
		forever begin
			#10 clk = 1;
			#10 clk = 0;
		end
	end

	initial begin
		#50ms;
		$display("testbench: errors");
		$finish;
	end

	function automatic sched_rsp_t schedule_step(sched_req_t r);
		sched_rsp_t o;
		int d, b, n, k, hits;
		logic first;
		o = '0;
		d = r.is_write;
		b = r.bank;
		case (r.operation)
			OP_STORE: begin
				if (mq_cnt[d][b] >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					mq_row[d][b][mq_cnt[d][b]] = r.row;
					mq_tag[d][b][mq_cnt[d][b]] = r.request_tag;
					mq_cnt[d][b]++;
				end
			end
			OP_REMOVE: begin
				served_write = r.is_write;
				o.status = ST_NOTFOUND;
				k = 0;
				for (int i = 0; i < mq_cnt[d][b]; i++) begin
					if (mq_tag[d][b][i] == r.request_tag) begin
						o.status = ST_OK;
					end else begin
						mq_row[d][b][k] = mq_row[d][b][i];
						mq_tag[d][b][k] = mq_tag[d][b][i];
						k++;
					end
				end
				mq_cnt[d][b] = k;
			end
			OP_SELECT: begin
				first = served_write;
				for (int p = 0; p < 2 && !o.found; p++) begin
					d = first ^ p[0];
					n = mq_cnt[d][b];
					if (n > 0) begin
						o.found = 1;
						o.chosen_is_write = d[0];
						o.chosen_tag = mq_tag[d][b][0];
						if (r.bank_active) begin
							for (int i = n - 1; i >= 0; i--)
								if (mq_row[d][b][i] == r.open_row)
									o.chosen_tag = mq_tag[d][b][i];
						end
					end
				end
			end
			default: begin
				hits = 0;
				for (int i = 0; i < mq_cnt[d][b]; i++)
					if (mq_row[d][b][i] == r.row)
						hits++;
				o.further_row_hit = hits >= HIT_THRESHOLD;
				o.further_request = mq_cnt[d][b] >= HIT_THRESHOLD;
			end
		endcase
		return o;
	endfunction

	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			g = 0;
		repeat (g) @(negedge clk);
	endtask

	task automatic send_req(sched_req_t r, logic typed, sched_rsp_t want);
		sched_rsp_t p;
		s_tvalid = 1;
		s_tdata = (IN_BYTES*8)'(r);
		do
			@(posedge clk);
		while (!s_tready);
		p = schedule_step(r);
		if (typed && p !== want) begin
			$error("directed row %0d: table %h differs from predictor %h", beats_in, want, p);
			errors++;
		end
		pending_rsp = {pending_rsp, p};
		beats_in++;
		case (r.operation)
			OP_STORE: n_store++;
			OP_REMOVE: n_remove++;
			OP_SELECT: n_select++;
			default: n_query++;
		endcase
		@(negedge clk);
		s_tvalid = 0;
	endtask

	function automatic sched_req_t rand_req(int bias_bank);
		sched_req_t r;
		int d;
		r = sched_req_t'($bits(sched_req_t)'({$urandom, $urandom}));
		r.bank = bias_bank >= 0 ? bias_bank[3:0] : r.bank;
		r.row = 17'({14'd0, r.row[2:0]} | ($urandom_range(0, 15) == 0 ? $urandom : 17'd0));
		r.open_row = 17'({14'd0, r.open_row[2:0]} |
			($urandom_range(0, 15) == 0 ? $urandom : 17'd0));
		d = r.is_write;
		if (r.operation == OP_REMOVE && mq_cnt[d][r.bank] > 0 && $urandom_range(0, 3) != 0)
			r.request_tag = mq_tag[d][r.bank][$urandom_range(0, mq_cnt[d][r.bank] - 1)];
		else
			r.request_tag = 8'($urandom_range(0, 3) != 0 ? $urandom_range(0, 15) : $urandom);
		return r;
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int g;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_hold) begin
				m_tready <= 0;
				repeat (60) @(negedge clk);
				stall_hold = 0;
			end
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 2);
			if ($urandom_range(0, 2) == 0)
				g = 0;
			if (g > 0) begin
				m_tready <= 0;
				repeat (g - 1) @(negedge clk);
			end else begin
				m_tready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		sched_rsp_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[13:0];
			beats_out++;
			if (pending_rsp.size() == 0) begin
				$error("result beat with nothing pending: %h", got);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d got %0d", want.status, got.status);
					errors++;
				end
				if (got.found !== want.found) begin
					$error("found: expected %0d got %0d", want.found, got.found);
					errors++;
				end
				if (got.chosen_tag !== want.chosen_tag) begin
					$error("chosen_tag: expected %0d got %0d", want.chosen_tag,
						got.chosen_tag);
					errors++;
				end
				if (got.chosen_is_write !== want.chosen_is_write) begin
					$error("chosen_is_write: expected %0d got %0d", want.chosen_is_write,
						got.chosen_is_write);
					errors++;
				end
				if (got.further_row_hit !== want.further_row_hit) begin
					$error("further_row_hit: expected %0d got %0d", want.further_row_hit,
						got.further_row_hit);
					errors++;
				end
				if (got.further_request !== want.further_request) begin
					$error("further_request: expected %0d got %0d", want.further_request,
						got.further_request);
					errors++;
				end
			end
		end
	end

	initial begin
		drill_row_t drill[$];
		drill_row_t dr;
		sched_req_t r;
		int wait_cnt, bb;
		errors = 0;
		beats_in = 0;
		beats_out = 0;
		n_store = 0;
		n_remove = 0;
		n_select = 0;
		n_query = 0;
		stall_hold = 0;
		served_write = 0;
		foreach (mq_cnt[d, b])
			mq_cnt[d][b] = 0;
		s_tvalid = 0;
		s_tdata = '0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed table: empty bank, extremes, full queue, duplicates, misses
		drill = {drill, drill_row_t'{'{17'h1ffff, 1'b1, 8'd0, 17'd0, 1'b0, 4'd0, OP_SELECT}, 1,
			'{0, 0, 0, 8'd0, 0, ST_OK}}};
		drill = {drill, drill_row_t'{'{17'd0, 1'b0, 8'd5, 17'd0, 1'b1, 4'd15, OP_REMOVE}, 1,
			'{0, 0, 0, 8'd0, 0, ST_NOTFOUND}}};
		for (int i = 0; i < 9; i++)
			drill = {drill, drill_row_t'{'{17'd0, 1'b0, 8'(i == 8 ? 255 : i * 3),
				17'(i < 4 ? 17'h1ffff : i), 1'b0, 4'd15, OP_STORE}, i == 8,
				'{0, 0, 0, 8'd0, 0, ST_FULL}}};
		drill = {drill, drill_row_t'{'{17'd0, 1'b0, 8'd0, 17'h1ffff, 1'b0, 4'd15, OP_QUERY},
			0, '0}};
		drill = {drill, drill_row_t'{'{17'h1ffff, 1'b1, 8'd0, 17'd0, 1'b0, 4'd15, OP_SELECT},
			0, '0}};
		drill = {drill, drill_row_t'{'{17'd6, 1'b1, 8'd0, 17'd0, 1'b0, 4'd15, OP_SELECT},
			0, '0}};
		drill = {drill, drill_row_t'{'{17'd0, 1'b0, 8'd255, 17'd9, 1'b1, 4'd15, OP_STORE},
			0, '0}};
		drill = {drill, drill_row_t'{'{17'd0, 1'b0, 8'd255, 17'd9, 1'b1, 4'd15, OP_STORE},
			0, '0}};
		drill = {drill, drill_row_t'{'{17'd0, 1'b0, 8'd255, 17'd0, 1'b1, 4'd15, OP_REMOVE},
			0, '0}};
		drill = {drill, drill_row_t'{'{17'd0, 1'b0, 8'd0, 17'd0, 1'b0, 4'd15, OP_SELECT},
			0, '0}};
		drill = {drill, drill_row_t'{'{17'd0, 1'b0, 8'd0, 17'd0, 1'b0, 4'd15, OP_REMOVE},
			0, '0}};
		drill = {drill, drill_row_t'{'{17'd0, 1'b0, 8'd3, 17'd0, 1'b0, 4'd15, OP_REMOVE},
			0, '0}};
		drill = {drill, drill_row_t'{'{17'd0, 1'b0, 8'd0, 17'd0, 1'b0, 4'd15, OP_QUERY},
			0, '0}};
		drill = {drill, drill_row_t'{'{17'd7, 1'b1, 8'd0, 17'd0, 1'b0, 4'd15, OP_SELECT},
			0, '0}};
		foreach (drill[i]) begin
			dr = drill[i];
			send_req(dr.req, dr.typed, dr.rsp);
			idle_gap();
		end

		// fill up behind a long receiver hold-off
		stall_hold = 1;
		for (int i = 0; i < 40; i++) begin
			r = rand_req(i % 4);
			send_req(r, 0, '0);
		end

		// random traffic, mostly focused on a few banks so queues fill and drain
		for (int i = 0; i < 1340; i++) begin
			bb = ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, 3);
			r = rand_req(bb);
			if (i % 300 < 150 && r.operation == OP_REMOVE && $urandom_range(0, 1) == 0)
				r.operation = OP_STORE;
			send_req(r, 0, '0);
			if (i == 600) begin
				while (pending_rsp.size() != 0)
					@(negedge clk);
			end else if ($urandom_range(0, 1) == 0) begin
				idle_gap();
			end
		end

		wait_cnt = 0;
		while (pending_rsp.size() != 0 && wait_cnt < 20000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (10) @(negedge clk);
		if (pending_rsp.size() != 0) begin
			$error("%0d results never arrived", pending_rsp.size());
			errors++;
		end
		$display("covered %0d beats in, %0d out: %0d store, %0d remove, %0d select, %0d query",
			beats_in, beats_out, n_store, n_remove, n_select, n_query);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== grouped_frfcfs_dram_scheduler_core.f =====
rtl/core/gfds_pkg.sv
rtl/core/gfds_cell.sv
rtl/core/gfds_queue.sv
rtl/core/grouped_frfcfs_dram_scheduler_core.sv
dv/testbench.sv
